### src/sssg_pkg.sv
package sssg_pkg;

  localparam int MAX_SCREEN_DIM_DEF = 4096;

  localparam int NUM_VERT  = 10;
  localparam int NUM_PAIR  = 5;
  localparam int PIDX_W    = $clog2(NUM_PAIR);

  localparam int CRD_W     = 13;
  localparam int RAD_W     = 10;
  localparam int ROT_W     = 10;
  localparam int COLOR_W   = 24;
  localparam int ROW_W     = 12;
  localparam int START_W   = 12;
  localparam int END_W     = 13;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

  localparam int ANG_W     = 9;
  localparam int SIN_W     = 12;
  localparam int SIN_SHIFT = 10;
  localparam int VTX_W     = 14;
  localparam int DIFF_W    = 15;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int QUO_W     = 11;
  localparam int DEN_W     = 11;
  localparam int DIV_LAT   = QUO_W + 2;
  localparam int SORT_LAT  = NUM_VERT;
  localparam int QDEPTH    = 4;

  localparam int RECIP_W       = 28;
  localparam logic [RECIP_W-1:0] INNER_RECIP = 28'd205084722;
  localparam int INNER_SHIFT   = 29;

  localparam longint HALF_PI_Q16 = 102944;
  localparam int DEG_FULL    = 360;
  localparam int DEG_QUARTER = 90;
  localparam int DEG_STEP    = 36;

  typedef logic signed [SIN_W-1:0] sin_tab_t [0:DEG_QUARTER-1];

  function automatic sin_tab_t build_sin_tab(input bit comp);
    sin_tab_t tab;
    longint x;
    longint x2;
    longint x3;
    longint x5;
    longint x7;
    longint s;
    for (int r = 0; r < DEG_QUARTER; r++) begin
      x = (HALF_PI_Q16 * r) / DEG_QUARTER;
      if (comp) x = HALF_PI_Q16 - x;
      x2 = (x * x) >>> 16;
      x3 = (x2 * x) >>> 16;
      x5 = (x3 * x2) >>> 16;
      x7 = (x5 * x2) >>> 16;
      s = x - x3 / 6 + x5 / 120 - x7 / 5040;
      tab[r] = SIN_W'((s * 1024) / 65536);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_DIRECT = build_sin_tab(1'b0);
  localparam sin_tab_t SIN_COMP   = build_sin_tab(1'b1);

  typedef struct packed {
    logic [NUM_PAIR-1:0][START_W-1:0] x0;
    logic [NUM_PAIR-1:0][END_W-1:0]   x1;
    logic [NUM_PAIR-1:0]              mask;
    logic [ROW_W-1:0]                 row;
    logic [COLOR_W-1:0]               color;
  } span_set_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/sssg_div.sv
module sssg_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sssg_pkg::PROD_W-1:0] num,
  input  logic signed [sssg_pkg::DIFF_W-1:0] den,
  input  logic signed [sssg_pkg::VTX_W-1:0]  base,
  output logic signed [sssg_pkg::VTX_W-1:0]  x
);

  localparam int QW = sssg_pkg::QUO_W;
  localparam int DW = sssg_pkg::DEN_W;
  localparam int PW = sssg_pkg::PROD_W;
  localparam int VW = sssg_pkg::VTX_W;

  logic [PW-1:0]                     num_mag;
  logic [sssg_pkg::DIFF_W-1:0]       den_mag;

  logic [DW-1:0]        rem_r  [0:QW];
  logic [QW-1:0]        low_r  [0:QW];
  logic [QW-1:0]        quo_r  [0:QW];
  logic [DW-1:0]        dm_r   [0:QW];
  logic                 neg_r  [0:QW];
  logic signed [VW-1:0] base_r [0:QW];
  logic signed [VW-1:0] x_r;
  logic signed [QW:0]   q_s;

  assign num_mag = num[PW-1] ? PW'(-num) : PW'(num);
  assign den_mag = den[sssg_pkg::DIFF_W-1] ? sssg_pkg::DIFF_W'(-den) : sssg_pkg::DIFF_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(num_mag[2*QW-1:QW]);
      low_r[0]  <= num_mag[QW-1:0];
      quo_r[0]  <= '0;
      dm_r[0]   <= DW'(den_mag);
      neg_r[0]  <= num[PW-1] ^ den[sssg_pkg::DIFF_W-1];
      base_r[0] <= base;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [DW:0] cand;
    logic        ge;
    assign cand = {rem_r[j-1], low_r[j-1][QW-1]};
    assign ge   = cand >= {1'b0, dm_r[j-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= ge ? DW'(cand - {1'b0, dm_r[j-1]}) : DW'(cand);
        low_r[j]  <= {low_r[j-1][QW-2:0], 1'b0};
        quo_r[j]  <= {quo_r[j-1][QW-2:0], ge};
        dm_r[j]   <= dm_r[j-1];
        neg_r[j]  <= neg_r[j-1];
        base_r[j] <= base_r[j-1];
      end
    end
  end

  assign q_s = $signed({1'b0, quo_r[QW]});

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= base_r[QW] + (neg_r[QW] ? VW'(-q_s) : VW'(q_s));
    end
  end

  assign x = x_r;

endmodule

### src/sssg_front.sv
module sssg_front #(
  parameter int MAX_SCREEN_DIM = sssg_pkg::MAX_SCREEN_DIM_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_req,
  input  logic signed [sssg_pkg::CRD_W-1:0]  center_x,
  input  logic signed [sssg_pkg::CRD_W-1:0]  center_y,
  input  logic [sssg_pkg::RAD_W-1:0]         outer_radius,
  input  logic [sssg_pkg::ROT_W-1:0]         rotation_deg,
  input  logic [sssg_pkg::COLOR_W-1:0]       fill_color,
  input  logic [sssg_pkg::ROW_W-1:0]         row,
  input  logic [sssg_pkg::CFG_W-1:0]         screen_width,
  input  logic [sssg_pkg::CFG_W-1:0]         screen_height,
  output logic                               fo_valid,
  output sssg_pkg::span_set_t                fo_set
);

  localparam int DIM_W = $clog2(MAX_SCREEN_DIM + 1);
  localparam int NV    = sssg_pkg::NUM_VERT;
  localparam int NP    = sssg_pkg::NUM_PAIR;
  localparam int VW    = sssg_pkg::VTX_W;
  localparam int DFW   = sssg_pkg::DIFF_W;
  localparam int SW    = sssg_pkg::SIN_W;
  localparam int RW    = sssg_pkg::RAD_W;
  localparam int AW    = sssg_pkg::ANG_W;
  localparam int PVW   = RW + 1 + SW;
  localparam int OFW   = PVW - sssg_pkg::SIN_SHIFT;
  localparam int CNT_W = $clog2(NV + 1);
  localparam int DL    = sssg_pkg::DIV_LAT;
  localparam int SL    = sssg_pkg::SORT_LAT;

  typedef struct packed {
    logic [sssg_pkg::ROW_W-1:0]   row;
    logic [sssg_pkg::COLOR_W-1:0] color;
    logic                         skip;
  } side_t;

  function automatic logic signed [SW-1:0] sine_lu(input logic [AW-1:0] d);
    logic [AW-1:0]          rem;
    logic                   neg;
    logic                   comp;
    logic signed [SW-1:0]   mag;
    if (d >= AW'(3 * sssg_pkg::DEG_QUARTER)) begin
      rem = d - AW'(3 * sssg_pkg::DEG_QUARTER);
      comp = 1'b1;
      neg = 1'b1;
    end else if (d >= AW'(2 * sssg_pkg::DEG_QUARTER)) begin
      rem = d - AW'(2 * sssg_pkg::DEG_QUARTER);
      comp = 1'b0;
      neg = 1'b1;
    end else if (d >= AW'(sssg_pkg::DEG_QUARTER)) begin
      rem = d - AW'(sssg_pkg::DEG_QUARTER);
      comp = 1'b1;
      neg = 1'b0;
    end else begin
      rem = d;
      comp = 1'b0;
      neg = 1'b0;
    end
    mag = comp ? sssg_pkg::SIN_COMP[rem[6:0]] : sssg_pkg::SIN_DIRECT[rem[6:0]];
    return neg ? -mag : mag;
  endfunction

  // screen clamp and early reject
  logic [DIM_W-1:0] w_cl;
  logic [DIM_W-1:0] h_cl;
  logic             skip_in;

  assign w_cl = (32'(screen_width) > MAX_SCREEN_DIM) ? DIM_W'(MAX_SCREEN_DIM)
                                                     : DIM_W'(screen_width);
  assign h_cl = (32'(screen_height) > MAX_SCREEN_DIM) ? DIM_W'(MAX_SCREEN_DIM)
                                                      : DIM_W'(screen_height);
  assign skip_in = (outer_radius == '0) || (w_cl == '0) || (h_cl == '0) ||
                   (32'(row) >= 32'(h_cl));

  // stage 1: capture
  logic                               v1_r;
  logic signed [sssg_pkg::CRD_W-1:0]  cx1_r, cy1_r;
  logic [RW-1:0]                      rad1_r;
  logic [sssg_pkg::ROT_W-1:0]         rot1_r;
  side_t                              side1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r    <= in_req;
      cx1_r   <= center_x;
      cy1_r   <= center_y;
      rad1_r  <= outer_radius;
      rot1_r  <= rotation_deg;
      side1_r <= '{row: row, color: fill_color, skip: skip_in};
    end
  end

  // stage 2: rotation modulo and inner radius
  logic [sssg_pkg::ROT_W-1:0]         rot_m;
  logic [RW+sssg_pkg::RECIP_W-1:0]    iprod;
  logic                               v2_r;
  logic signed [sssg_pkg::CRD_W-1:0]  cx2_r, cy2_r;
  logic [RW-1:0]                      rad2_r, inner2_r;
  logic [AW-1:0]                      d0_2_r;
  side_t                              side2_r;

  always_comb begin
    if (rot1_r >= sssg_pkg::ROT_W'(2 * sssg_pkg::DEG_FULL)) begin
      rot_m = rot1_r - sssg_pkg::ROT_W'(2 * sssg_pkg::DEG_FULL);
    end else if (rot1_r >= sssg_pkg::ROT_W'(sssg_pkg::DEG_FULL)) begin
      rot_m = rot1_r - sssg_pkg::ROT_W'(sssg_pkg::DEG_FULL);
    end else begin
      rot_m = rot1_r;
    end
  end

  assign iprod = (RW + sssg_pkg::RECIP_W)'(rad1_r) *
                 (RW + sssg_pkg::RECIP_W)'(sssg_pkg::INNER_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r     <= v1_r;
      cx2_r    <= cx1_r;
      cy2_r    <= cy1_r;
      rad2_r   <= rad1_r;
      inner2_r <= RW'(iprod >> sssg_pkg::INNER_SHIFT);
      d0_2_r   <= AW'(rot_m);
      side2_r  <= side1_r;
    end
  end

  // stage 3: vertex angles and sine lookup
  logic signed [SW-1:0]               cos_c [0:NV-1];
  logic signed [SW-1:0]               sin_c [0:NV-1];
  logic signed [SW-1:0]               cos3_r [0:NV-1];
  logic signed [SW-1:0]               sin3_r [0:NV-1];
  logic                               v3_r;
  logic signed [sssg_pkg::CRD_W-1:0]  cx3_r, cy3_r;
  logic [RW-1:0]                      rad3_r, inner3_r;
  side_t                              side3_r;

  for (genvar i = 0; i < NV; i++) begin : g_ang
    logic [AW:0]   dc_raw;
    logic [AW:0]   ds_raw;
    logic [AW-1:0] dc;
    logic [AW-1:0] ds;
    assign dc_raw = {1'b0, d0_2_r} + (AW + 1)'(sssg_pkg::DEG_STEP * i);
    assign dc = (dc_raw >= (AW + 1)'(sssg_pkg::DEG_FULL))
              ? AW'(dc_raw - (AW + 1)'(sssg_pkg::DEG_FULL)) : dc_raw[AW-1:0];
    assign ds_raw = {1'b0, dc} + (AW + 1)'(3 * sssg_pkg::DEG_QUARTER);
    assign ds = (ds_raw >= (AW + 1)'(sssg_pkg::DEG_FULL))
              ? AW'(ds_raw - (AW + 1)'(sssg_pkg::DEG_FULL)) : ds_raw[AW-1:0];
    assign cos_c[i] = sine_lu(dc);
    assign sin_c[i] = sine_lu(ds);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r     <= v2_r;
      cos3_r   <= cos_c;
      sin3_r   <= sin_c;
      cx3_r    <= cx2_r;
      cy3_r    <= cy2_r;
      rad3_r   <= rad2_r;
      inner3_r <= inner2_r;
      side3_r  <= side2_r;
    end
  end

  // stage 4: radius times sine
  logic signed [PVW-1:0]              px_c [0:NV-1];
  logic signed [PVW-1:0]              py_c [0:NV-1];
  logic signed [PVW-1:0]              px4_r [0:NV-1];
  logic signed [PVW-1:0]              py4_r [0:NV-1];
  logic                               v4_r;
  logic signed [sssg_pkg::CRD_W-1:0]  cx4_r, cy4_r;
  side_t                              side4_r;

  for (genvar i = 0; i < NV; i++) begin : g_mul
    logic signed [RW:0] r_s;
    assign r_s = (i % 2 == 1) ? $signed({1'b0, inner3_r}) : $signed({1'b0, rad3_r});
    assign px_c[i] = r_s * cos3_r[i];
    assign py_c[i] = r_s * sin3_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r    <= v3_r;
      px4_r   <= px_c;
      py4_r   <= py_c;
      cx4_r   <= cx3_r;
      cy4_r   <= cy3_r;
      side4_r <= side3_r;
    end
  end

  // stage 5: truncate toward zero and offset by center
  logic signed [VW-1:0]  vx_c [0:NV-1];
  logic signed [VW-1:0]  vy_c [0:NV-1];
  logic signed [VW-1:0]  vx5_r [0:NV-1];
  logic signed [VW-1:0]  vy5_r [0:NV-1];
  logic                  v5_r;
  side_t                 side5_r;

  for (genvar i = 0; i < NV; i++) begin : g_vtx
    logic signed [PVW-1:0] ax;
    logic signed [PVW-1:0] ay;
    logic signed [OFW-1:0] ox;
    logic signed [OFW-1:0] oy;
    assign ax = px4_r[i] + $signed(PVW'(px4_r[i][PVW-1] ? (1 << sssg_pkg::SIN_SHIFT) - 1 : 0));
    assign ay = py4_r[i] + $signed(PVW'(py4_r[i][PVW-1] ? (1 << sssg_pkg::SIN_SHIFT) - 1 : 0));
    assign ox = OFW'(ax >>> sssg_pkg::SIN_SHIFT);
    assign oy = OFW'(ay >>> sssg_pkg::SIN_SHIFT);
    assign vx_c[i] = VW'(cx4_r) + VW'(ox);
    assign vy_c[i] = VW'(cy4_r) + VW'(oy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r    <= v4_r;
      vx5_r   <= vx_c;
      vy5_r   <= vy_c;
      side5_r <= side4_r;
    end
  end

  // stage 6: edge crossing test and deltas
  logic signed [VW-1:0]  rs;
  logic [NV-1:0]         cr_c;
  logic signed [DFW-1:0] dx_c [0:NV-1];
  logic signed [DFW-1:0] dy_c [0:NV-1];
  logic signed [DFW-1:0] t_c  [0:NV-1];
  logic [NV-1:0]         cr6_r;
  logic signed [DFW-1:0] dx6_r [0:NV-1];
  logic signed [DFW-1:0] dy6_r [0:NV-1];
  logic signed [DFW-1:0] t6_r  [0:NV-1];
  logic signed [VW-1:0]  xa6_r [0:NV-1];
  logic                  v6_r;
  side_t                 side6_r;

  assign rs = $signed(VW'(side5_r.row));

  for (genvar i = 0; i < NV; i++) begin : g_edge
    localparam int K = (i + 1) % NV;
    assign cr_c[i] = ((vy5_r[i] <= rs) && (vy5_r[K] > rs)) ||
                     ((vy5_r[K] <= rs) && (vy5_r[i] > rs));
    assign dx_c[i] = DFW'(vx5_r[K]) - DFW'(vx5_r[i]);
    assign dy_c[i] = DFW'(vy5_r[K]) - DFW'(vy5_r[i]);
    assign t_c[i]  = DFW'(rs) - DFW'(vy5_r[i]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r    <= v5_r;
      cr6_r   <= cr_c;
      dx6_r   <= dx_c;
      dy6_r   <= dy_c;
      t6_r    <= t_c;
      xa6_r   <= vx5_r;
      side6_r <= side5_r;
    end
  end

  // stage 7: numerator product
  logic signed [sssg_pkg::PROD_W-1:0] num_c  [0:NV-1];
  logic signed [sssg_pkg::PROD_W-1:0] num7_r [0:NV-1];
  logic signed [DFW-1:0]              dy7_r  [0:NV-1];
  logic signed [VW-1:0]               xa7_r  [0:NV-1];
  logic [NV-1:0]                      cr7_r;
  logic                               v7_r;
  side_t                              side7_r;

  for (genvar i = 0; i < NV; i++) begin : g_num
    assign num_c[i] = dx6_r[i] * t6_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r    <= v6_r;
      num7_r  <= num_c;
      dy7_r   <= dy6_r;
      xa7_r   <= xa6_r;
      cr7_r   <= cr6_r;
      side7_r <= side6_r;
    end
  end

  // crossing x per edge, one divider lane each
  logic signed [VW-1:0] xs_d [0:NV-1];

  for (genvar i = 0; i < NV; i++) begin : g_div
    sssg_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num7_r[i]),
      .den  (dy7_r[i]),
      .base (xa7_r[i]),
      .x    (xs_d[i])
    );
  end

  logic          dl_v_r    [0:DL-1];
  side_t         dl_side_r [0:DL-1];
  logic [NV-1:0] dl_cr_r   [0:DL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DL; s++) dl_v_r[s] <= 1'b0;
    end else if (en) begin
      dl_v_r[0]    <= v7_r;
      dl_side_r[0] <= side7_r;
      dl_cr_r[0]   <= cr7_r;
      for (int s = 1; s < DL; s++) begin
        dl_v_r[s]    <= dl_v_r[s-1];
        dl_side_r[s] <= dl_side_r[s-1];
        dl_cr_r[s]   <= dl_cr_r[s-1];
      end
    end
  end

  // odd-even transposition sort, unused edges sink to the top
  logic signed [VW-1:0] srt_r  [0:SL][0:NV-1];
  logic                 sv_r   [0:SL];
  side_t                sside_r[0:SL];
  logic [CNT_W-1:0]     sn_r   [0:SL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= SL; s++) sv_r[s] <= 1'b0;
    end else if (en) begin
      sv_r[0]    <= dl_v_r[DL-1];
      sside_r[0] <= dl_side_r[DL-1];
      sn_r[0]    <= CNT_W'($countones(dl_cr_r[DL-1]));
      for (int s = 1; s <= SL; s++) begin
        sv_r[s]    <= sv_r[s-1];
        sside_r[s] <= sside_r[s-1];
        sn_r[s]    <= sn_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NV; i++) begin
        srt_r[0][i] <= dl_cr_r[DL-1][i] ? xs_d[i] : VW'((1 << (VW - 1)) - 1);
      end
    end
  end

  for (genvar s = 1; s <= SL; s++) begin : g_sort
    logic signed [VW-1:0] nx [0:NV-1];
    always_comb begin
      for (int i = 0; i < NV; i++) nx[i] = srt_r[s-1][i];
      for (int i = s % 2; i + 1 < NV; i += 2) begin
        if (srt_r[s-1][i+1] < srt_r[s-1][i]) begin
          nx[i]   = srt_r[s-1][i+1];
          nx[i+1] = srt_r[s-1][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) srt_r[s] <= nx;
    end
  end

  // pairing and clipping
  logic signed [31:0]  w_s;
  sssg_pkg::span_set_t set_c;
  sssg_pkg::span_set_t set_r;
  logic                fo_v_r;

  assign w_s = $signed(32'(w_cl));

  for (genvar k = 0; k < NP; k++) begin : g_pair
    logic signed [31:0] x0s;
    logic signed [31:0] x1s;
    logic signed [31:0] x0c;
    logic signed [31:0] x1c;
    assign x0s = 32'(srt_r[SL][2*k]);
    assign x1s = 32'(srt_r[SL][2*k+1]) + 32'sd1;
    assign x0c = (x0s < 0) ? 32'sd0 : x0s;
    assign x1c = (x1s > w_s) ? w_s : x1s;
    assign set_c.x0[k]   = sssg_pkg::START_W'(x0c);
    assign set_c.x1[k]   = sssg_pkg::END_W'(x1c);
    assign set_c.mask[k] = !sside_r[SL].skip && (32'(sn_r[SL]) > 2 * k + 1) && (x1c > x0c);
  end

  assign set_c.row   = sside_r[SL].row;
  assign set_c.color = sside_r[SL].color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fo_v_r <= 1'b0;
    end else if (en) begin
      fo_v_r <= sv_r[SL] && (set_c.mask != '0);
      set_r  <= set_c;
    end
  end

  assign fo_valid = fo_v_r;
  assign fo_set   = set_r;

endmodule

### src/sssg_queue.sv
module sssg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sssg_pkg::span_set_t din,
  input  logic                pop,
  output sssg_pkg::span_set_t dout,
  output sssg_pkg::q_stat_t   stat
);

  localparam int DEPTH = sssg_pkg::QDEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sssg_pkg::span_set_t mem_r [0:DEPTH-1];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### src/sssg_back.sv
module sssg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sssg_pkg::q_stat_t            q_stat,
  input  sssg_pkg::span_set_t          head,
  output logic                         pop,
  output logic                         out_valid,
  output logic [sssg_pkg::START_W-1:0] out_span_start,
  output logic [sssg_pkg::END_W-1:0]   out_span_end,
  output logic [sssg_pkg::ROW_W-1:0]   out_span_row,
  output logic [sssg_pkg::COLOR_W-1:0] out_span_color,
  output logic                         out_last_span
);

  localparam int NP = sssg_pkg::NUM_PAIR;

  sssg_pkg::span_set_t         cur_r;
  logic [NP-1:0]               mask_r;
  logic [sssg_pkg::PIDX_W-1:0] sel_idx;
  logic [NP-1:0]               rest;
  logic                        have;
  logic                        load;

  logic                         valid_r;
  logic [sssg_pkg::START_W-1:0] start_r;
  logic [sssg_pkg::END_W-1:0]   end_r;
  logic [sssg_pkg::ROW_W-1:0]   row_r;
  logic [sssg_pkg::COLOR_W-1:0] color_r;
  logic                         last_r;

  always_comb begin
    sel_idx = '0;
    for (int k = NP - 1; k >= 0; k--) begin
      if (mask_r[k]) sel_idx = sssg_pkg::PIDX_W'(k);
    end
  end

  assign have = (mask_r != '0);
  assign rest = mask_r & ~(NP'(1) << sel_idx);
  assign load = !q_stat.empty && (!have || (rest == '0));
  assign pop  = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= have;
      if (load) mask_r <= head.mask;
      else if (have) mask_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= head;
    if (have) begin
      start_r <= cur_r.x0[sel_idx];
      end_r   <= cur_r.x1[sel_idx];
      row_r   <= cur_r.row;
      color_r <= cur_r.color;
      last_r  <= (rest == '0);
    end
  end

  assign out_valid      = valid_r;
  assign out_span_start = start_r;
  assign out_span_end   = end_r;
  assign out_span_row   = row_r;
  assign out_span_color = color_r;
  assign out_last_span  = last_r;

endmodule

### src/star_scanline_span_generator_top.sv
// channel  direction  handshake            payload
// in       input      start & !busy        center_x, center_y, outer_radius, rotation_deg,
//                                          fill_color, row
// out      output     out_valid strobe     span_start, span_end, span_row, span_color, last_span
// cfg      input      cfg_valid & ready    cfg_index, cfg_data
//
// one request can enter every cycle while busy is low; the span port sends
// one span a cycle, and a row with no spans takes no port time; the 4-entry
// span queue sets the slack; busy rises and the whole front pipeline holds
// while that queue is full and the front holds a set to push
// the receiver cannot stall; rst_n is synchronous and restores 1024 x 768
module star_scanline_span_generator_top #(
  parameter int MAX_SCREEN_DIM = sssg_pkg::MAX_SCREEN_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [sssg_pkg::CRD_W-1:0]   in_center_x,
  input  logic signed [sssg_pkg::CRD_W-1:0]   in_center_y,
  input  logic [sssg_pkg::RAD_W-1:0]          in_outer_radius,
  input  logic [sssg_pkg::ROT_W-1:0]          in_rotation_deg,
  input  logic [sssg_pkg::COLOR_W-1:0]        in_fill_color,
  input  logic [sssg_pkg::ROW_W-1:0]          in_row,
  output logic                                out_valid,
  output logic [sssg_pkg::START_W-1:0]        out_span_start,
  output logic [sssg_pkg::END_W-1:0]          out_span_end,
  output logic [sssg_pkg::ROW_W-1:0]          out_span_row,
  output logic [sssg_pkg::COLOR_W-1:0]        out_span_color,
  output logic                                out_last_span,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sssg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sssg_pkg::CFG_W-1:0]          cfg_data
);

  logic [sssg_pkg::CFG_W-1:0] screen_width_r;
  logic [sssg_pkg::CFG_W-1:0] screen_height_r;

  logic                 en;
  logic                 fo_valid;
  sssg_pkg::span_set_t  fo_set;
  sssg_pkg::span_set_t  q_head;
  sssg_pkg::q_stat_t    q_stat;
  logic                 q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= sssg_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= sssg_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sssg_pkg::REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        sssg_pkg::REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en   = !(fo_valid && q_stat.full);
  assign busy = !en;

  sssg_front #(
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .in_req        (start && !busy),
    .center_x      (in_center_x),
    .center_y      (in_center_y),
    .outer_radius  (in_outer_radius),
    .rotation_deg  (in_rotation_deg),
    .fill_color    (in_fill_color),
    .row           (in_row),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .fo_valid      (fo_valid),
    .fo_set        (fo_set)
  );

  sssg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fo_valid && en),
    .din   (fo_set),
    .pop   (q_pop),
    .dout  (q_head),
    .stat  (q_stat)
  );

  sssg_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (q_head),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_span_start (out_span_start),
    .out_span_end   (out_span_end),
    .out_span_row   (out_span_row),
    .out_span_color (out_span_color),
    .out_last_span  (out_last_span)
  );

endmodule
